// ===== rtl/core/stok_pkg.sv =====
// stok_pkg: types, token codes and the keyword lookup shared by the tokenizer files.
// No dependencies.
package stok_pkg;

    localparam int OFF_BITS  = 24;
    localparam int LINE_BITS = 24;
    localparam int COL_BITS  = 16;
    localparam int CSUM_BITS = ((OFF_BITS > COL_BITS) ? OFF_BITS : COL_BITS) + 1;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};

    localparam int MAX_RESULTS   = 3;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // token codes
    localparam logic [5:0] TK_PLUS    = 6'd0;
    localparam logic [5:0] TK_PLUSEQ  = 6'd1;
    localparam logic [5:0] TK_MINUS   = 6'd2;
    localparam logic [5:0] TK_ARROW   = 6'd3;
    localparam logic [5:0] TK_STAR    = 6'd4;
    localparam logic [5:0] TK_SLASH   = 6'd5;
    localparam logic [5:0] TK_EQ      = 6'd6;
    localparam logic [5:0] TK_MATCH   = 6'd7;
    localparam logic [5:0] TK_DCOLON  = 6'd8;
    localparam logic [5:0] TK_COLON   = 6'd9;
    localparam logic [5:0] TK_DOTDOT  = 6'd10;
    localparam logic [5:0] TK_DOT     = 6'd11;
    localparam logic [5:0] TK_COMMA   = 6'd12;
    localparam logic [5:0] TK_OBRACK  = 6'd13;
    localparam logic [5:0] TK_CBRACK  = 6'd14;
    localparam logic [5:0] TK_OBRACE  = 6'd15;
    localparam logic [5:0] TK_CBRACE  = 6'd16;
    localparam logic [5:0] TK_OPAREN  = 6'd17;
    localparam logic [5:0] TK_CPAREN  = 6'd18;
    localparam logic [5:0] TK_SEMI    = 6'd19;
    localparam logic [5:0] TK_AT      = 6'd20;
    localparam logic [5:0] TK_AMP     = 6'd21;
    localparam logic [5:0] TK_PIPE    = 6'd22;
    localparam logic [5:0] TK_CARET   = 6'd23;
    localparam logic [5:0] TK_TILDE   = 6'd24;
    localparam logic [5:0] TK_NE      = 6'd25;
    localparam logic [5:0] TK_QUEST   = 6'd26;
    localparam logic [5:0] TK_SHL     = 6'd27;
    localparam logic [5:0] TK_LE      = 6'd28;
    localparam logic [5:0] TK_LT      = 6'd29;
    localparam logic [5:0] TK_SHR     = 6'd30;
    localparam logic [5:0] TK_GE      = 6'd31;
    localparam logic [5:0] TK_GT      = 6'd32;
    localparam logic [5:0] TK_HASH    = 6'd33;
    localparam logic [5:0] TK_STRING  = 6'd34;
    localparam logic [5:0] TK_NUMBER  = 6'd35;
    localparam logic [5:0] TK_IDENT   = 6'd36;
    localparam logic [5:0] TK_UNKNOWN = 6'd37;
    localparam logic [5:0] TK_END     = 6'd38;
    localparam logic [5:0] TK_NSPACE  = 6'd39;
    localparam logic [5:0] TK_CLASS   = 6'd40;
    localparam logic [5:0] TK_PUBLIC  = 6'd41;
    localparam logic [5:0] TK_PRIVATE = 6'd42;
    localparam logic [5:0] TK_FN      = 6'd43;
    localparam logic [5:0] TK_INIT    = 6'd44;
    localparam logic [5:0] TK_SELF    = 6'd45;
    localparam logic [5:0] TK_OPER    = 6'd46;
    localparam logic [5:0] TK_STRKW   = 6'd47;
    localparam logic [5:0] TK_RETURN  = 6'd48;
    localparam logic [5:0] TK_MODULE  = 6'd49;
    localparam logic [5:0] TK_ERROR   = 6'd50;
    localparam logic [5:0] TK_NONE    = 6'd63;

    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_EOS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_req;
    } in_item_t;

    typedef struct packed {
        logic [5:0]           token_kind;
        logic [OFF_BITS-1:0]  start_offset;
        logic [OFF_BITS-1:0]  length;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  column;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_RESULTS-1:0]    item;
    } push_t;

    typedef struct packed {
        logic [FIFO_CNT_BITS-1:0] count;
        logic                     room;
    } fifo_status_t;

    // first nine word characters, index 0 first; n is 0 when the word is longer
    function automatic logic [5:0] word_kind(input logic [0:8][7:0] c, input logic [3:0] n);
        logic [5:0] k;
        k = TK_IDENT;
        case (n)
            4'd2: if (c[0:1] == "fn") k = TK_FN;
            4'd4: begin
                if (c[0:3] == "init") k = TK_INIT;
                else if (c[0:3] == "self") k = TK_SELF;
            end
            4'd5: if (c[0:4] == "class") k = TK_CLASS;
            4'd6: begin
                if (c[0:5] == "public") k = TK_PUBLIC;
                else if (c[0:5] == "string") k = TK_STRKW;
                else if (c[0:5] == "return") k = TK_RETURN;
                else if (c[0:5] == "module") k = TK_MODULE;
            end
            4'd7: if (c[0:6] == "private") k = TK_PRIVATE;
            4'd8: if (c[0:7] == "operator") k = TK_OPER;
            4'd9: if (c[0:8] == "namespace") k = TK_NSPACE;
            default: k = TK_IDENT;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/stok_lexer.sv =====
// stok_lexer: scan state and the single-pass next-state and token logic.
// Depends on stok_pkg.
module stok_lexer #(
    parameter int KEYWORD_CHARS = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  stok_pkg::in_item_t in_data,
    output stok_pkg::push_t   push
);

    localparam int WL_BITS  = $clog2(KEYWORD_CHARS + 2);
    localparam int IDX_BITS = $clog2(KEYWORD_CHARS);
    localparam int OB = stok_pkg::OFF_BITS;
    localparam int LB = stok_pkg::LINE_BITS;
    localparam int CB = stok_pkg::COL_BITS;
    localparam int SB = stok_pkg::CSUM_BITS;

    typedef enum logic [4:0] {
        M_IDLE, M_PLUS, M_MINUS, M_EQ, M_COLON, M_DOT, M_BANG, M_LT, M_GT,
        M_SLASH, M_NBSP, M_COMMENT, M_STRING, M_IDENT, M_NZERO, M_NINT,
        M_NDOT, M_NFRAC, M_NHEX
    } mode_t;

    mode_t          mode_reg, mode_next;
    logic           qd_reg, qd_next;
    logic [OB-1:0]  pos_reg, pos_next;
    logic [LB-1:0]  ln_reg, ln_next;
    logic [CB-1:0]  col_reg, col_next;
    logic [OB-1:0]  ts_reg, ts_next;
    logic [LB-1:0]  tl_reg, tl_next;
    logic [CB-1:0]  tc_reg, tc_next;
    logic [WL_BITS-1:0] wl_reg, wl_next;
    logic           sa_reg, sa_next;
    logic           acr_reg, acr_next;
    logic [7:0]     prefix_reg [KEYWORD_CHARS];

    logic                pw_en;
    logic [IDX_BITS-1:0] pw_idx;
    logic [7:0]          pw_data;

    stok_pkg::result_t [2:0] res;
    logic [1:0]    n;
    logic          sa, go;
    logic [7:0]    b;
    logic [OB-1:0] posm1, span, nlen;
    logic [SB-1:0] csum;
    logic [CB-1:0] tc_split;
    logic [5:0]    wkind, two, lone, single;
    logic [0:8][7:0] first9;
    logic [3:0]    wlen4;

    function automatic stok_pkg::result_t mk(input logic [5:0] k, input logic [OB-1:0] st,
                                             input logic [OB-1:0] len, input logic [LB-1:0] l,
                                             input logic [CB-1:0] c);
        stok_pkg::result_t r;
        r.token_kind   = k;
        r.start_offset = st;
        r.length       = len;
        r.line         = l;
        r.column       = c;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic logic allows(input logic [5:0] k);
        return (k == stok_pkg::TK_IDENT) || (k == stok_pkg::TK_NUMBER) ||
               (k == stok_pkg::TK_CPAREN) || (k == stok_pkg::TK_SELF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "*":     k = stok_pkg::TK_STAR;
            ",":     k = stok_pkg::TK_COMMA;
            "[":     k = stok_pkg::TK_OBRACK;
            "]":     k = stok_pkg::TK_CBRACK;
            "{":     k = stok_pkg::TK_OBRACE;
            "}":     k = stok_pkg::TK_CBRACE;
            "(":     k = stok_pkg::TK_OPAREN;
            ")":     k = stok_pkg::TK_CPAREN;
            ";":     k = stok_pkg::TK_SEMI;
            "@":     k = stok_pkg::TK_AT;
            "&":     k = stok_pkg::TK_AMP;
            "|":     k = stok_pkg::TK_PIPE;
            "^":     k = stok_pkg::TK_CARET;
            "~":     k = stok_pkg::TK_TILDE;
            "?":     k = stok_pkg::TK_QUEST;
            "#":     k = stok_pkg::TK_HASH;
            default: k = stok_pkg::TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] lone_kind(input mode_t m);
        logic [5:0] k;
        case (m)
            M_PLUS:  k = stok_pkg::TK_PLUS;
            M_MINUS: k = stok_pkg::TK_MINUS;
            M_EQ:    k = stok_pkg::TK_EQ;
            M_COLON: k = stok_pkg::TK_COLON;
            M_DOT:   k = stok_pkg::TK_DOT;
            M_LT:    k = stok_pkg::TK_LT;
            M_GT:    k = stok_pkg::TK_GT;
            default: k = stok_pkg::TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] op_two(input mode_t m, input logic [7:0] c);
        logic [5:0] k;
        k = stok_pkg::TK_NONE;
        case (m)
            M_PLUS:  if (c == "=") k = stok_pkg::TK_PLUSEQ;
            M_MINUS: if (c == ">") k = stok_pkg::TK_ARROW;
            M_EQ: begin
                if (c == ">") k = stok_pkg::TK_ARROW;
                else if (c == "=") k = stok_pkg::TK_MATCH;
            end
            M_COLON: if (c == ":") k = stok_pkg::TK_DCOLON;
            M_DOT:   if (c == ".") k = stok_pkg::TK_DOTDOT;
            M_BANG:  if (c == "=") k = stok_pkg::TK_NE;
            M_LT: begin
                if (c == "<") k = stok_pkg::TK_SHL;
                else if (c == "=") k = stok_pkg::TK_LE;
            end
            M_GT: begin
                if (c == ">") k = stok_pkg::TK_SHR;
                else if (c == "=") k = stok_pkg::TK_GE;
            end
            default: k = stok_pkg::TK_NONE;
        endcase
        return k;
    endfunction

    // shared arithmetic on the pending token
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            first9[i] = prefix_reg[i];
        end
        wlen4    = (wl_reg <= WL_BITS'(9)) ? wl_reg[3:0] : 4'd0;
        wkind    = stok_pkg::word_kind(first9, wlen4);
        b        = in_data.byte_req;
        posm1    = pos_reg - OB'(1);
        span     = pos_reg - ts_reg;
        nlen     = posm1 - ts_reg;
        csum     = SB'(tc_reg) + SB'(nlen);
        tc_split = (csum > SB'(stok_pkg::COL_MAX)) ? stok_pkg::COL_MAX : csum[CB-1:0];
        two      = op_two(mode_reg, b);
        lone     = lone_kind(mode_reg);
        single   = single_kind(b);
    end

    always_comb begin
        mode_next = mode_reg;
        qd_next   = qd_reg;
        pos_next  = pos_reg;
        ln_next   = ln_reg;
        col_next  = col_reg;
        ts_next   = ts_reg;
        tl_next   = tl_reg;
        tc_next   = tc_reg;
        wl_next   = wl_reg;
        acr_next  = acr_reg;
        pw_en     = 1'b0;
        pw_idx    = wl_reg[IDX_BITS-1:0];
        pw_data   = b;
        res       = '0;
        n         = 2'd0;
        sa        = sa_reg;
        go        = 1'b0;

        if (in_data.kind == stok_pkg::IN_EOS) begin
            case (mode_reg)
                M_SLASH: begin
                    res[n] = mk(stok_pkg::TK_SLASH, ts_reg, OB'(1), tl_reg, tc_reg);
                    n = n + 2'd1; sa = 1'b0;
                end
                M_NBSP: begin
                    res[n] = mk(stok_pkg::TK_UNKNOWN, ts_reg, OB'(1), tl_reg, tc_reg);
                    n = n + 2'd1; sa = 1'b0;
                end
                M_IDENT: begin
                    res[n] = mk(wkind, ts_reg, span, tl_reg, tc_reg);
                    n = n + 2'd1; sa = allows(wkind);
                end
                M_NZERO, M_NINT, M_NFRAC, M_NHEX: begin
                    res[n] = mk(stok_pkg::TK_NUMBER, ts_reg, span, tl_reg, tc_reg);
                    n = n + 2'd1; sa = 1'b1;
                end
                M_NDOT: begin
                    res[n] = mk(stok_pkg::TK_NUMBER, ts_reg, nlen, tl_reg, tc_reg);
                    n = n + 2'd1;
                    res[n] = mk(stok_pkg::TK_DOT, posm1, OB'(1), tl_reg, tc_split);
                    n = n + 2'd1; sa = 1'b0;
                end
                M_PLUS, M_MINUS, M_EQ, M_COLON, M_DOT, M_LT, M_GT: begin
                    res[n] = mk(lone, ts_reg, OB'(1), tl_reg, tc_reg);
                    n = n + 2'd1; sa = 1'b0;
                end
                default: ;
            endcase
            if (mode_reg == M_STRING) begin
                // open string: error alone
                res[n] = mk(stok_pkg::TK_ERROR, ts_reg, span, tl_reg, tc_reg);
                n = n + 2'd1;
            end else begin
                if (sa) begin
                    res[n] = mk(stok_pkg::TK_SEMI, pos_reg, OB'(0), ln_reg, col_reg);
                    n = n + 2'd1;
                end
                res[n] = mk(stok_pkg::TK_END, pos_reg, OB'(0), ln_reg, col_reg);
                n = n + 2'd1;
            end
            mode_next = M_IDLE;
            qd_next   = 1'b0;
            pos_next  = '0;
            ln_next   = LB'(1);
            col_next  = CB'(1);
            ts_next   = '0;
            tl_next   = LB'(1);
            tc_next   = CB'(1);
            wl_next   = '0;
            acr_next  = 1'b0;
            sa        = 1'b0;
        end else if (acr_reg && (b == 8'h0A)) begin
            // LF of a CRLF pair
            acr_next = 1'b0;
            pos_next = pos_reg + OB'(1);
        end else begin
            case (mode_reg)
                M_IDLE: go = 1'b1;
                M_SLASH: begin
                    if (b == "/") begin
                        mode_next = M_COMMENT;
                    end else begin
                        res[n] = mk(stok_pkg::TK_SLASH, ts_reg, OB'(1), tl_reg, tc_reg);
                        n = n + 2'd1; sa = 1'b0; go = 1'b1;
                    end
                end
                M_NBSP: begin
                    if (b == 8'hA0) begin
                        mode_next = M_IDLE;
                    end else begin
                        res[n] = mk(stok_pkg::TK_UNKNOWN, ts_reg, OB'(1), tl_reg, tc_reg);
                        n = n + 2'd1; sa = 1'b0; go = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if ((b == 8'h0A) || (b == 8'h0D)) go = 1'b1;
                end
                M_STRING: begin
                    if (b == (qd_reg ? 8'h22 : 8'h27)) begin
                        res[n] = mk(stok_pkg::TK_STRING, ts_reg + OB'(1), nlen, tl_reg, tc_reg);
                        n = n + 2'd1; sa = 1'b0;
                        mode_next = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(b) || is_digit(b) || (b == "_")) begin
                        if (wl_reg < WL_BITS'(KEYWORD_CHARS)) pw_en = 1'b1;
                        if (wl_reg <= WL_BITS'(KEYWORD_CHARS)) wl_next = wl_reg + WL_BITS'(1);
                    end else begin
                        res[n] = mk(wkind, ts_reg, span, tl_reg, tc_reg);
                        n = n + 2'd1; sa = allows(wkind); go = 1'b1;
                    end
                end
                M_NZERO, M_NINT: begin
                    if ((mode_reg == M_NZERO) && ((b == "x") || (b == "X"))) begin
                        mode_next = M_NHEX;
                    end else if (is_digit(b)) begin
                        mode_next = M_NINT;
                    end else if (b == ".") begin
                        mode_next = M_NDOT;
                    end else begin
                        res[n] = mk(stok_pkg::TK_NUMBER, ts_reg, span, tl_reg, tc_reg);
                        n = n + 2'd1; sa = 1'b1; go = 1'b1;
                    end
                end
                M_NDOT: begin
                    if (is_digit(b)) begin
                        mode_next = M_NFRAC;
                    end else begin
                        // number ends before the dot; the dot is resolved on its own
                        res[n] = mk(stok_pkg::TK_NUMBER, ts_reg, nlen, tl_reg, tc_reg);
                        n = n + 2'd1;
                        if (b == ".") begin
                            res[n] = mk(stok_pkg::TK_DOTDOT, posm1, OB'(2), tl_reg, tc_split);
                            n = n + 2'd1; sa = 1'b0;
                            mode_next = M_IDLE;
                            ts_next   = posm1;
                            tc_next   = tc_split;
                        end else begin
                            res[n] = mk(stok_pkg::TK_DOT, posm1, OB'(1), tl_reg, tc_split);
                            n = n + 2'd1; sa = 1'b0; go = 1'b1;
                        end
                    end
                end
                M_NFRAC, M_NHEX: begin
                    if (!((mode_reg == M_NFRAC) ? is_digit(b) : is_hex(b))) begin
                        res[n] = mk(stok_pkg::TK_NUMBER, ts_reg, span, tl_reg, tc_reg);
                        n = n + 2'd1; sa = 1'b1; go = 1'b1;
                    end
                end
                M_PLUS, M_MINUS, M_EQ, M_COLON, M_DOT, M_BANG, M_LT, M_GT: begin
                    if (two != stok_pkg::TK_NONE) begin
                        res[n] = mk(two, ts_reg, OB'(2), tl_reg, tc_reg);
                        n = n + 2'd1; sa = 1'b0;
                        mode_next = M_IDLE;
                    end else begin
                        if (lone != stok_pkg::TK_NONE) begin
                            res[n] = mk(lone, ts_reg, OB'(1), tl_reg, tc_reg);
                            n = n + 2'd1; sa = 1'b0;
                        end
                        go = 1'b1;
                    end
                end
                default: go = 1'b1;
            endcase

            if (go) begin
                ts_next   = pos_reg;
                tl_next   = ln_reg;
                tc_next   = col_reg;
                mode_next = M_IDLE;
                case (b)
                    8'h20, 8'h09: ;
                    8'h0A, 8'h0D: begin
                        if (sa) begin
                            res[n] = mk(stok_pkg::TK_SEMI, pos_reg, OB'(0), ln_reg, col_reg);
                            n = n + 2'd1; sa = 1'b0;
                        end
                    end
                    8'hC2: mode_next = M_NBSP;
                    "+":   mode_next = M_PLUS;
                    "-":   mode_next = M_MINUS;
                    "=":   mode_next = M_EQ;
                    ":":   mode_next = M_COLON;
                    ".":   mode_next = M_DOT;
                    "!":   mode_next = M_BANG;
                    "<":   mode_next = M_LT;
                    ">":   mode_next = M_GT;
                    "/":   mode_next = M_SLASH;
                    8'h22, 8'h27: begin
                        mode_next = M_STRING;
                        qd_next   = (b == 8'h22);
                    end
                    default: begin
                        if (single != stok_pkg::TK_NONE) begin
                            res[n] = mk(single, pos_reg, OB'(1), ln_reg, col_reg);
                            n = n + 2'd1; sa = allows(single);
                        end else if (is_digit(b)) begin
                            mode_next = (b == "0") ? M_NZERO : M_NINT;
                        end else if (is_alpha(b) || (b == "_")) begin
                            pw_en     = 1'b1;
                            pw_idx    = '0;
                            wl_next   = WL_BITS'(1);
                            mode_next = M_IDENT;
                        end else begin
                            res[n] = mk(stok_pkg::TK_UNKNOWN, pos_reg, OB'(1), ln_reg, col_reg);
                            n = n + 2'd1; sa = 1'b0;
                        end
                    end
                endcase
            end

            acr_next = (b == 8'h0D);
            pos_next = pos_reg + OB'(1);
            if ((b == 8'h0A) || (b == 8'h0D)) begin
                if (ln_reg != stok_pkg::LINE_MAX) ln_next = ln_reg + LB'(1);
                col_next = CB'(1);
            end else if (col_reg != stok_pkg::COL_MAX) begin
                col_next = col_reg + CB'(1);
            end
        end

        sa_next = sa;
        if (n != 2'd0) res[n - 2'd1].last = 1'b1;
        push.item  = res;
        push.count = accept ? n : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            qd_reg   <= 1'b0;
            pos_reg  <= '0;
            ln_reg   <= LB'(1);
            col_reg  <= CB'(1);
            ts_reg   <= '0;
            tl_reg   <= LB'(1);
            tc_reg   <= CB'(1);
            wl_reg   <= '0;
            sa_reg   <= 1'b0;
            acr_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            qd_reg   <= qd_next;
            pos_reg  <= pos_next;
            ln_reg   <= ln_next;
            col_reg  <= col_next;
            ts_reg   <= ts_next;
            tl_reg   <= tl_next;
            tc_reg   <= tc_next;
            wl_reg   <= wl_next;
            sa_reg   <= sa_next;
            acr_reg  <= acr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pw_en) begin
            prefix_reg[pw_idx] <= pw_data;
        end
    end

endmodule

// ===== rtl/core/stok_result_fifo.sv =====
// stok_result_fifo: result queue taking up to three tokens a cycle, one out a cycle while m_ready is high.
// Depends on stok_pkg.
module stok_result_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  stok_pkg::push_t         push,
    output stok_pkg::fifo_status_t  status,
    output logic                    m_valid,
    input  logic                    m_ready,
    output stok_pkg::result_t       m_data
);

    localparam int DEPTH = stok_pkg::FIFO_DEPTH;
    localparam int PW    = stok_pkg::FIFO_PTR_BITS;
    localparam int CW    = stok_pkg::FIFO_CNT_BITS;

    stok_pkg::result_t mem [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wptr_next  = wptr_reg + PW'(push.count);
        rptr_next  = rptr_reg + PW'(pop);
        count_next = count_reg + CW'(push.count) - CW'(pop);
        status.count = count_reg;
        // room for a full burst of results from one transfer
        status.room  = (count_reg <= CW'(DEPTH - stok_pkg::MAX_RESULTS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < stok_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < push.count) begin
                mem[wptr_reg + PW'(i)] <= push.item[i];
            end
        end
    end

endmodule

// ===== rtl/core/source_tokenizer.sv =====
// source_tokenizer: top level, byte stream in, token stream out.
// Depends on stok_pkg, stok_lexer, stok_result_fifo.
//
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    stok_pkg::in_item_t  (kind, byte_req)
//  m_        out  m_valid/m_ready    stok_pkg::result_t   (token fields, last)
//
// One byte or end-of-source per cycle while s_ready is high; each transfer updates the
// scan state in the same cycle and queues zero to three tokens in the result queue.
// The queue drains one token a cycle while m_ready is high; s_ready drops while
// it lacks room for three more, so a long run of multi-token bytes or a stalled
// m_ready throttles input. aresetn is synchronous and clears the queue and scan state.
module source_tokenizer #(
    parameter int KEYWORD_CHARS = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stok_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output stok_pkg::result_t  m_data
);

    stok_pkg::push_t        push;
    stok_pkg::fifo_status_t fifo_status;
    logic                   accept;

    assign s_ready = fifo_status.room;
    assign accept  = s_valid && s_ready;

    stok_lexer #(
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_data (s_data),
        .push    (push)
    );

    stok_result_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .status  (fifo_status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    // queue never overfills
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_status.count <= stok_pkg::FIFO_CNT_BITS'(stok_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // end token closes its transfer and has no text
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.token_kind == stok_pkg::TK_END) |-> m_data.last && (m_data.length == '0))
        else $error("end token malformed");

    // nothing queued without a transfer
    a_push_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |-> (push.count == 2'd0))
        else $error("tokens pushed without a transfer");
`endif

endmodule

// ===== verif/tb_source_tokenizer.sv =====
// tb_source_tokenizer: self-checking bench for the streaming source tokenizer.
// Depends on stok_pkg and source_tokenizer; an in-bench lexer predicts the token stream.
`timescale 1ns / 100ps

class token_scoreboard;
    stok_pkg::result_t pending[$];
    int errors;

    // lexer state
    typedef enum int {SC_IDLE, SC_PLUS, SC_MINUS, SC_EQ, SC_COLON, SC_DOT, SC_BANG,
        SC_LT, SC_GT, SC_SLASH, SC_NBSP, SC_COMMENT, SC_STRING, SC_IDENT, SC_NZERO,
        SC_NINT, SC_NDOT, SC_NFRAC, SC_NHEX} scan_t;
    scan_t mode;
    bit dq, semi_ok, after_cr;
    logic [23:0] pos, tstart, tline, lnum;
    logic [15:0] tcol, cnum;
    logic [7:0] word [0:8];
    int wlen;
    stok_pkg::result_t batch[$];

    function void clear();
        mode = SC_IDLE; dq = 0; semi_ok = 0; after_cr = 0;
        pos = 0; tstart = 0; tline = 1; lnum = 1; tcol = 1; cnum = 1; wlen = 0;
    endfunction

    function void put(logic [5:0] k, logic [23:0] s, logic [23:0] l,
                      logic [23:0] ln, logic [15:0] col);
        stok_pkg::result_t r;
        r.token_kind = k; r.start_offset = s; r.length = l;
        r.line = ln; r.column = col; r.last = 0;
        if (batch.size() < 3) batch.insert(batch.size(), r);
        semi_ok = (k == stok_pkg::TK_IDENT || k == stok_pkg::TK_NUMBER ||
                   k == stok_pkg::TK_CPAREN || k == stok_pkg::TK_SELF);
    endfunction

    function void put_tok(logic [5:0] k, logic [23:0] l);
        put(k, tstart, l, tline, tcol);
    endfunction

    function logic [5:0] keyword();
        string kw[11];
        logic [5:0] code[11];
        int j;
        bit hit;
        kw = '{"namespace", "class", "public", "private", "fn", "init", "self",
               "operator", "string", "return", "module"};
        code = '{stok_pkg::TK_NSPACE, stok_pkg::TK_CLASS, stok_pkg::TK_PUBLIC,
                 stok_pkg::TK_PRIVATE, stok_pkg::TK_FN, stok_pkg::TK_INIT,
                 stok_pkg::TK_SELF, stok_pkg::TK_OPER, stok_pkg::TK_STRKW,
                 stok_pkg::TK_RETURN, stok_pkg::TK_MODULE};
        foreach (kw[i]) begin
            if (kw[i].len() == wlen) begin
                hit = 1;
                for (j = 0; j < wlen; j++) if (word[j] != kw[i][j]) hit = 0;
                if (hit) return code[i];
            end
        end
        return stok_pkg::TK_IDENT;
    endfunction

    function logic [5:0] lone(scan_t m);
        case (m)
            SC_PLUS:  return stok_pkg::TK_PLUS;
            SC_MINUS: return stok_pkg::TK_MINUS;
            SC_EQ:    return stok_pkg::TK_EQ;
            SC_COLON: return stok_pkg::TK_COLON;
            SC_DOT:   return stok_pkg::TK_DOT;
            SC_LT:    return stok_pkg::TK_LT;
            SC_GT:    return stok_pkg::TK_GT;
            default:  return stok_pkg::TK_NONE;
        endcase
    endfunction

    function void split_dot(logic [23:0] p);
        logic [23:0] nlen;
        logic [24:0] c;
        nlen = p - 24'd1 - tstart;
        c = tcol + nlen;
        put_tok(stok_pkg::TK_NUMBER, nlen);
        tcol = (c > 25'hffff) ? 16'hffff : c[15:0];
        tstart = p - 24'd1;
        mode = SC_DOT;
    endfunction

    static function bit digit(logic [7:0] b); return b >= "0" && b <= "9"; endfunction
    static function bit alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function logic [5:0] single(logic [7:0] b);
        case (b)
            "*": return stok_pkg::TK_STAR;   ",": return stok_pkg::TK_COMMA;
            "[": return stok_pkg::TK_OBRACK; "]": return stok_pkg::TK_CBRACK;
            "{": return stok_pkg::TK_OBRACE; "}": return stok_pkg::TK_CBRACE;
            "(": return stok_pkg::TK_OPAREN; ")": return stok_pkg::TK_CPAREN;
            ";": return stok_pkg::TK_SEMI;   "@": return stok_pkg::TK_AT;
            "&": return stok_pkg::TK_AMP;    "|": return stok_pkg::TK_PIPE;
            "^": return stok_pkg::TK_CARET;  "~": return stok_pkg::TK_TILDE;
            "?": return stok_pkg::TK_QUEST;  "#": return stok_pkg::TK_HASH;
            default: return stok_pkg::TK_NONE;
        endcase
    endfunction

    function void begin_token(logic [7:0] b);
        logic [5:0] k;
        tstart = pos; tline = lnum; tcol = cnum; mode = SC_IDLE;
        case (b)
            " ", 8'h09: return;
            8'h0a, 8'h0d: begin
                if (semi_ok) put(stok_pkg::TK_SEMI, pos, 0, lnum, cnum);
                return;
            end
            8'hc2: begin mode = SC_NBSP; return; end
            "+": begin mode = SC_PLUS; return; end
            "-": begin mode = SC_MINUS; return; end
            "=": begin mode = SC_EQ; return; end
            ":": begin mode = SC_COLON; return; end
            ".": begin mode = SC_DOT; return; end
            "!": begin mode = SC_BANG; return; end
            "<": begin mode = SC_LT; return; end
            ">": begin mode = SC_GT; return; end
            "/": begin mode = SC_SLASH; return; end
            8'h22, 8'h27: begin mode = SC_STRING; dq = (b == 8'h22); return; end
            default: ;
        endcase
        k = single(b);
        if (k != stok_pkg::TK_NONE) begin put_tok(k, 1); return; end
        if (digit(b)) begin mode = (b == "0") ? SC_NZERO : SC_NINT; return; end
        if (alpha(b) || b == "_") begin
            word[0] = b; wlen = 1; mode = SC_IDENT; return;
        end
        put_tok(stok_pkg::TK_UNKNOWN, 1);
    endfunction

    function void lex(logic [7:0] b);
        bit done;
        logic [5:0] two;
        done = 0;
        while (!done) begin
            case (mode)
                SC_IDLE: begin begin_token(b); done = 1; end
                SC_SLASH:
                    if (b == "/") begin mode = SC_COMMENT; done = 1; end
                    else begin put_tok(stok_pkg::TK_SLASH, 1); mode = SC_IDLE; end
                SC_NBSP:
                    if (b == 8'ha0) begin mode = SC_IDLE; done = 1; end
                    else begin put_tok(stok_pkg::TK_UNKNOWN, 1); mode = SC_IDLE; end
                SC_COMMENT:
                    if (b == 8'h0a || b == 8'h0d) mode = SC_IDLE;
                    else done = 1;
                SC_STRING: begin
                    if (b == (dq ? 8'h22 : 8'h27)) begin
                        put(stok_pkg::TK_STRING, tstart + 24'd1, pos - tstart - 24'd1,
                            tline, tcol);
                        mode = SC_IDLE;
                    end
                    done = 1;
                end
                SC_IDENT:
                    if (alpha(b) || digit(b) || b == "_") begin
                        if (wlen < 9) word[wlen] = b;
                        if (wlen <= 9) wlen++;
                        done = 1;
                    end else begin
                        put_tok(keyword(), pos - tstart); mode = SC_IDLE;
                    end
                SC_NZERO, SC_NINT:
                    if (mode == SC_NZERO && (b == "x" || b == "X")) begin
                        mode = SC_NHEX; done = 1;
                    end else if (digit(b)) begin mode = SC_NINT; done = 1; end
                    else if (b == ".") begin mode = SC_NDOT; done = 1; end
                    else begin put_tok(stok_pkg::TK_NUMBER, pos - tstart); mode = SC_IDLE; end
                SC_NDOT:
                    if (digit(b)) begin mode = SC_NFRAC; done = 1; end
                    else split_dot(pos);
                SC_NFRAC, SC_NHEX:
                    if (mode == SC_NFRAC ? digit(b) :
                        (digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F")))
                        done = 1;
                    else begin put_tok(stok_pkg::TK_NUMBER, pos - tstart); mode = SC_IDLE; end
                default: begin
                    two = stok_pkg::TK_NONE;
                    case (mode)
                        SC_PLUS:  if (b == "=") two = stok_pkg::TK_PLUSEQ;
                        SC_MINUS: if (b == ">") two = stok_pkg::TK_ARROW;
                        SC_EQ:    if (b == ">") two = stok_pkg::TK_ARROW;
                                  else if (b == "=") two = stok_pkg::TK_MATCH;
                        SC_COLON: if (b == ":") two = stok_pkg::TK_DCOLON;
                        SC_DOT:   if (b == ".") two = stok_pkg::TK_DOTDOT;
                        SC_BANG:  if (b == "=") two = stok_pkg::TK_NE;
                        SC_LT:    if (b == "<") two = stok_pkg::TK_SHL;
                                  else if (b == "=") two = stok_pkg::TK_LE;
                        SC_GT:    if (b == ">") two = stok_pkg::TK_SHR;
                                  else if (b == "=") two = stok_pkg::TK_GE;
                        default: ;
                    endcase
                    if (two != stok_pkg::TK_NONE) begin
                        put_tok(two, 2); done = 1;
                    end else if (lone(mode) != stok_pkg::TK_NONE) begin
                        put_tok(lone(mode), 1);
                    end
                    mode = SC_IDLE;
                end
            endcase
        end
    endfunction

    function void end_of_source();
        case (mode)
            SC_IDLE, SC_COMMENT, SC_BANG: ;
            SC_SLASH: put_tok(stok_pkg::TK_SLASH, 1);
            SC_NBSP: put_tok(stok_pkg::TK_UNKNOWN, 1);
            SC_STRING: begin put_tok(stok_pkg::TK_ERROR, pos - tstart); return; end
            SC_IDENT: put_tok(keyword(), pos - tstart);
            SC_NZERO, SC_NINT, SC_NFRAC, SC_NHEX: put_tok(stok_pkg::TK_NUMBER, pos - tstart);
            SC_NDOT: begin split_dot(pos); put_tok(stok_pkg::TK_DOT, 1); end
            default: if (lone(mode) != stok_pkg::TK_NONE) put_tok(lone(mode), 1);
        endcase
        if (semi_ok) put(stok_pkg::TK_SEMI, pos, 0, lnum, cnum);
        put(stok_pkg::TK_END, pos, 0, lnum, cnum);
    endfunction

    // note an accepted input transfer and queue the tokens it yields
    function void note_input(stok_pkg::in_item_t it);
        batch.delete();
        if (it.kind == stok_pkg::IN_EOS) begin
            end_of_source();
            clear();
        end else if (after_cr && it.byte_req == 8'h0a) begin
            after_cr = 0;
            pos++;
        end else begin
            after_cr = 0;
            lex(it.byte_req);
            after_cr = (it.byte_req == 8'h0d);
            pos++;
            if (it.byte_req == 8'h0a || it.byte_req == 8'h0d) begin
                if (lnum != stok_pkg::LINE_MAX) lnum++;
                cnum = 1;
            end else if (cnum != stok_pkg::COL_MAX) cnum++;
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1;
        foreach (batch[i]) pending.insert(pending.size(), batch[i]);
    endfunction

    function void check_result(stok_pkg::result_t got);
        stok_pkg::result_t exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected token: actual %p", $realtime, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got !== exp) begin
            $display("%0t: token mismatch: expected %p actual %p", $realtime, exp, got);
            errors++;
        end
    endfunction
endclass

module tb_source_tokenizer;
    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, m_ready = 0;
    logic s_ready, m_valid;
    stok_pkg::in_item_t s_data = '0;
    stok_pkg::result_t m_data;
    token_scoreboard lexer_sb;
    int send_idle = 0, recv_stall = 0, quiet_cycles = 0;
    bit timed_out = 0;

    source_tokenizer dut (.*);

    always begin #6 aclk = 1; #6 aclk = 0; end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) lexer_sb.note_input(s_data);
            if (m_valid && m_ready) lexer_sb.check_result(m_data);
            quiet_cycles <= ((s_valid && s_ready) || (m_valid && m_ready)) ? 0 : quiet_cycles + 1;
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles > 2000) begin
            timed_out = 1;
            $display("source_tokenizer regression: fail");
            $finish;
        end
    end

    // valid stays up after a transfer until the next item or an idle cycle replaces it
    task automatic send(logic k, logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{kind: k, byte_req: b};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_text(string t);
        foreach (t[i]) send(stok_pkg::IN_BYTE, t[i]);
    endtask

    task automatic send_random_source();
        string frags[24];
        int n;
        frags = '{"namespace", "class", "self", "fn", "init", "x_9", "operator",
                  "module", "0x1F", "12.5", "7.", "0X", "'ab'", "\"q\"", "// c\n",
                  "\r\n", "\n", "\r", "+= -> => == :: .. != << <= >> >= ", "!a",
                  "returns", "a.b", "(x)\n", "private public string return"};
        n = $urandom_range(3, 12);
        repeat (n) begin
            if ($urandom_range(9) < 7) send_text(frags[$urandom_range(23)]);
            else if ($urandom_range(1)) send(stok_pkg::IN_BYTE, 8'($urandom_range(255)));
            else send_text(string'({8'hc2, 8'ha0}));
            if ($urandom_range(3) == 0) send(stok_pkg::IN_BYTE, " ");
        end
        send(stok_pkg::IN_EOS, 8'($urandom_range(255)));
    endtask

    initial begin
        lexer_sb = new();
        lexer_sb.clear();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: operators, keywords, numbers, an open string, nbsp, bang, crlf
        send_text("self\r\n0x 1.x+=*");
        send(stok_pkg::IN_EOS, 8'hff);
        send_text(string'({"a!b", 8'hc2, "z", 8'hc2, 8'ha0, "'s"}));
        send(stok_pkg::IN_EOS, 8'h00);
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 52; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 52; end
                default: begin send_idle = 15; recv_stall = 15; end
            endcase
            repeat (2) send_random_source();
        end
        s_valid <= 0;
        while (lexer_sb.pending.size() != 0 && !timed_out) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (timed_out) $display("source_tokenizer regression: fail");
        else if (lexer_sb.errors == 0 && lexer_sb.pending.size() == 0)
            $display("source_tokenizer regression: pass");
        else $display("source_tokenizer regression: fail");
        $finish;
    end
endmodule
